FILE: sv/msmc_pkg.sv
// ----------------------------------------------------------------------------
// msmc_pkg: shared types and constants
// Mode, sound and animation codes, register indexes, configuration and
// internal word types for the motion saber mode controller.
// ----------------------------------------------------------------------------
package msmc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int ACCEL_W     = 16;
   localparam int SQ_W        = 2 * ACCEL_W - 1;
   localparam int MAG_W       = 32;
   localparam int FONT_W      = 4;
   localparam int FCOUNT_W    = 5;
   localparam int IDLE_W      = 16;
   localparam int SWING_W     = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_FONT_COUNT      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASH_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWING_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWING_DEBOUNCE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_TIMEOUT    = 3'd4;

   localparam logic [FCOUNT_W-1:0] FONT_COUNT_RESET      = 5'd4;
   localparam logic [MAG_W-1:0]    CLASH_THRESHOLD_RESET = 32'd25000000;
   localparam logic [MAG_W-1:0]    SWING_THRESHOLD_RESET = 32'd17000000;
   localparam logic [SWING_W-1:0]  SWING_DEBOUNCE_RESET  = 4'd4;
   localparam logic [IDLE_W-1:0]   IDLE_TIMEOUT_RESET    = 16'd500;

   localparam logic [FCOUNT_W-1:0] FONT_COUNT_MAX = 5'd16;

   typedef enum logic [2:0] {
      MODE_SLEEP  = 3'd0,
      MODE_FONT   = 3'd1,
      MODE_IDLE   = 3'd2,
      MODE_ON     = 3'd3,
      MODE_EFFECT = 3'd4,
      MODE_OFF    = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      SND_BOOT    = 3'd0,
      SND_IGNITE  = 3'd1,
      SND_RETRACT = 3'd2,
      SND_CLASH   = 3'd3,
      SND_SWING   = 3'd4
   } sound_kind_type;

   typedef enum logic [1:0] {
      ANI_SOLID   = 2'd0,
      ANI_EXTEND  = 2'd1,
      ANI_RETRACT = 2'd2
   } anim_kind_type;

   typedef struct packed {
      logic [FCOUNT_W-1:0] font_count;
      logic [MAG_W-1:0]    clash_threshold;
      logic [MAG_W-1:0]    swing_threshold;
      logic [SWING_W-1:0]  swing_debounce;
      logic [IDLE_W-1:0]   idle_timeout;
   } cfg_type;

   typedef struct packed {
      logic            button_down;
      logic            button_short;
      logic            button_long;
      logic            sound_finished;
      logic            anim_finished;
      logic [SQ_W-1:0] sq_x;
      logic [SQ_W-1:0] sq_y;
      logic [SQ_W-1:0] sq_z;
   } tick_type;

   typedef struct packed {
      logic              sound_start;
      sound_kind_type    sound_kind;
      logic              anim_start;
      anim_kind_type     anim_kind;
      logic              anim_dark;
      logic [FONT_W-1:0] font_index;
      mode_type          mode_now;
      logic              sleep_now;
   } result_type;

endpackage

FILE: sv/msmc_ifs.sv
// ----------------------------------------------------------------------------
// msmc channel interfaces
// Tick input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface msmc_req_if;
   import msmc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      button_down;
   logic                      button_short;
   logic                      button_long;
   logic                      sound_finished;
   logic                      anim_finished;
   logic signed [ACCEL_W-1:0] accel_x;
   logic signed [ACCEL_W-1:0] accel_y;
   logic signed [ACCEL_W-1:0] accel_z;

   modport source (
      output valid, button_down, button_short, button_long, sound_finished,
             anim_finished, accel_x, accel_y, accel_z,
      input  ready
   );
   modport sink (
      input  valid, button_down, button_short, button_long, sound_finished,
             anim_finished, accel_x, accel_y, accel_z,
      output ready
   );
endinterface

interface msmc_rsp_if;
   import msmc_pkg::*;

   logic              valid;
   logic              ready;
   logic              sound_start;
   sound_kind_type    sound_kind;
   logic              anim_start;
   anim_kind_type     anim_kind;
   logic              anim_dark;
   logic [FONT_W-1:0] font_index;
   mode_type          mode_now;
   logic              sleep_now;

   modport source (
      output valid, sound_start, sound_kind, anim_start, anim_kind, anim_dark,
             font_index, mode_now, sleep_now,
      input  ready
   );
   modport sink (
      input  valid, sound_start, sound_kind, anim_start, anim_kind, anim_dark,
             font_index, mode_now, sleep_now,
      output ready
   );
endinterface

interface msmc_csr_if;
   import msmc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/motion_saber_mode_controller.sv
// ----------------------------------------------------------------------------
// motion_saber_mode_controller: saber mode controller top level
// A tick's squares are registered in the input stage, then the mode logic
//   writes the result register, from which the result is offered.
// Throughput: one tick per cycle unless a result waits; then one tick is held.
// Reset: synchronous; mode sleep, counters and font cleared, registers to
//   their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module motion_saber_mode_controller (
   input logic        clock,
   input logic        reset,
   msmc_req_if.sink   req_bus,
   msmc_rsp_if.source rsp_bus,
   msmc_csr_if.sink   csr_bus
);
   import msmc_pkg::*;

   cfg_type  cfg;
   tick_type tick;
   logic     tick_valid;
   logic     take;

   msmc_csr_regs u_csr_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   msmc_accel_sq u_accel_sq (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .take       (take),
      .tick_valid (tick_valid),
      .tick       (tick)
   );

   msmc_mode_fsm u_mode_fsm (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .tick_valid (tick_valid),
      .tick       (tick),
      .take       (take),
      .rsp_bus    (rsp_bus)
   );

endmodule

FILE: sv/msmc_csr_regs.sv
// ----------------------------------------------------------------------------
// msmc_csr_regs: configuration registers
// Holds font count, thresholds, swing debounce and idle timeout.
// ----------------------------------------------------------------------------
module msmc_csr_regs (
   input  logic              clock,
   input  logic              reset,
   msmc_csr_if.sink          csr_bus,
   output msmc_pkg::cfg_type cfg
);
   import msmc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_FONT_COUNT:      cfg_in.font_count      = csr_bus.data[FCOUNT_W-1:0];
            CSR_CLASH_THRESHOLD: cfg_in.clash_threshold = csr_bus.data[MAG_W-1:0];
            CSR_SWING_THRESHOLD: cfg_in.swing_threshold = csr_bus.data[MAG_W-1:0];
            CSR_SWING_DEBOUNCE:  cfg_in.swing_debounce  = csr_bus.data[SWING_W-1:0];
            CSR_IDLE_TIMEOUT:    cfg_in.idle_timeout    = csr_bus.data[IDLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.font_count      <= FONT_COUNT_RESET;
         cfg_ff.clash_threshold <= CLASH_THRESHOLD_RESET;
         cfg_ff.swing_threshold <= SWING_THRESHOLD_RESET;
         cfg_ff.swing_debounce  <= SWING_DEBOUNCE_RESET;
         cfg_ff.idle_timeout    <= IDLE_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: sv/msmc_accel_sq.sv
// ----------------------------------------------------------------------------
// msmc_accel_sq: input stage
// Registers the tick flags and the three squared accelerometer axes.
// ----------------------------------------------------------------------------
module msmc_accel_sq (
   input  logic               clock,
   input  logic               reset,
   msmc_req_if.sink           req_bus,
   input  logic               take,
   output logic               tick_valid,
   output msmc_pkg::tick_type tick
);
   import msmc_pkg::*;

   logic                        valid_ff;
   logic                        valid_in;
   tick_type                    tick_ff;
   tick_type                    tick_in;
   logic signed [2*ACCEL_W-1:0] px;
   logic signed [2*ACCEL_W-1:0] py;
   logic signed [2*ACCEL_W-1:0] pz;
   logic                        accept;

   assign req_bus.ready = !valid_ff || take;
   assign accept        = req_bus.valid && req_bus.ready;
   assign tick_valid    = valid_ff;
   assign tick          = tick_ff;

   // squares are never negative; top bit always clear
   assign px = req_bus.accel_x * req_bus.accel_x;
   assign py = req_bus.accel_y * req_bus.accel_y;
   assign pz = req_bus.accel_z * req_bus.accel_z;

   always_comb begin
      tick_in.button_down    = req_bus.button_down;
      tick_in.button_short   = req_bus.button_short;
      tick_in.button_long    = req_bus.button_long;
      tick_in.sound_finished = req_bus.sound_finished;
      tick_in.anim_finished  = req_bus.anim_finished;
      tick_in.sq_x           = px[SQ_W-1:0];
      tick_in.sq_y           = py[SQ_W-1:0];
      tick_in.sq_z           = pz[SQ_W-1:0];
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tick_ff <= tick_in;
      end
   end

endmodule

FILE: sv/msmc_mode_fsm.sv
// ----------------------------------------------------------------------------
// msmc_mode_fsm: mode machine and result register
// Six-mode controller with idle and swing counters, font selection and
// clash/swing detection on the summed squared acceleration.
// ----------------------------------------------------------------------------
module msmc_mode_fsm (
   input  logic               clock,
   input  logic               reset,
   input  msmc_pkg::cfg_type  cfg,
   input  logic               tick_valid,
   input  msmc_pkg::tick_type tick,
   output logic               take,
   msmc_rsp_if.source         rsp_bus
);
   import msmc_pkg::*;

   mode_type            mode_ff;
   mode_type            mode_in;
   logic [IDLE_W-1:0]   idle_ff;
   logic [IDLE_W-1:0]   idle_in;
   logic [IDLE_W-1:0]   idle_inc;
   logic [SWING_W-1:0]  swing_ff;
   logic [SWING_W-1:0]  swing_in;
   logic [FONT_W-1:0]   font_ff;
   logic [FONT_W-1:0]   font_in;
   logic [FCOUNT_W-1:0] font_lim;
   logic [MAG_W-1:0]    mag;
   logic                out_valid_ff;
   logic                out_valid_in;
   result_type          result_ff;
   result_type          result_in;

   // (v mod n) for v <= 16, 1 <= n <= 16, restoring subtract
   function automatic logic [FONT_W-1:0] wrap_font(input logic [FCOUNT_W-1:0] v,
                                                   input logic [FCOUNT_W-1:0] n);
      logic [FCOUNT_W+3:0] r;
      logic [FCOUNT_W+3:0] d;
      r = {4'b0, v};
      for (int k = FCOUNT_W - 1; k >= 0; k--) begin
         d = {4'b0, n} << k;
         if (r >= d) begin
            r = r - d;
         end
      end
      return r[FONT_W-1:0];
   endfunction

   assign take = tick_valid && (!out_valid_ff || rsp_bus.ready);

   assign mag = MAG_W'(tick.sq_x) + MAG_W'(tick.sq_y) + MAG_W'(tick.sq_z);
   assign idle_inc = (idle_ff != {IDLE_W{1'b1}}) ? idle_ff + 1'b1 : idle_ff;

   always_comb begin
      if (cfg.font_count == '0) begin
         font_lim = FCOUNT_W'(1);
      end else if (cfg.font_count > FONT_COUNT_MAX) begin
         font_lim = FONT_COUNT_MAX;
      end else begin
         font_lim = cfg.font_count;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      idle_in  = idle_ff;
      swing_in = swing_ff;
      font_in  = font_ff;
      result_in.sound_start = 1'b0;
      result_in.sound_kind  = SND_BOOT;
      result_in.anim_start  = 1'b0;
      result_in.anim_kind   = ANI_SOLID;
      result_in.anim_dark   = 1'b0;
      result_in.sleep_now   = 1'b0;

      unique case (mode_ff)
         MODE_SLEEP: begin
            result_in.sleep_now   = 1'b1;
            result_in.sound_start = 1'b1;
            result_in.sound_kind  = SND_BOOT;
            mode_in = MODE_FONT;
         end
         MODE_FONT: begin
            if (tick.sound_finished) begin
               if (tick.button_down) begin
                  font_in = wrap_font(FCOUNT_W'(font_ff) + 1'b1, font_lim);
                  result_in.sound_start = 1'b1;
                  result_in.sound_kind  = SND_BOOT;
                  result_in.anim_start  = 1'b1;
                  result_in.anim_kind   = ANI_SOLID;
               end else begin
                  idle_in = '0;
                  mode_in = MODE_IDLE;
                  result_in.anim_start = 1'b1;
                  result_in.anim_kind  = ANI_SOLID;
                  result_in.anim_dark  = 1'b1;
               end
            end
         end
         MODE_IDLE: begin
            priority if (tick.button_short) begin
               result_in.sound_start = 1'b1;
               result_in.sound_kind  = SND_IGNITE;
               result_in.anim_start  = 1'b1;
               result_in.anim_kind   = ANI_EXTEND;
               mode_in = MODE_EFFECT;
            end else if (tick.button_long) begin
               mode_in = MODE_FONT;
            end else begin
               idle_in = idle_inc;
               if (idle_inc > cfg.idle_timeout) begin
                  mode_in = MODE_SLEEP;
               end
            end
         end
         MODE_ON: begin
            priority if (tick.button_short) begin
               result_in.sound_start = 1'b1;
               result_in.sound_kind  = SND_RETRACT;
               result_in.anim_start  = 1'b1;
               result_in.anim_kind   = ANI_RETRACT;
               mode_in = MODE_OFF;
            end else if (mag > cfg.clash_threshold) begin
               result_in.sound_start = 1'b1;
               result_in.sound_kind  = SND_CLASH;
               mode_in = MODE_EFFECT;
            end else if (mag > cfg.swing_threshold) begin
               if (swing_ff > cfg.swing_debounce) begin
                  result_in.sound_start = 1'b1;
                  result_in.sound_kind  = SND_SWING;
                  mode_in = MODE_EFFECT;
               end else if (swing_ff != {SWING_W{1'b1}}) begin
                  swing_in = swing_ff + 1'b1;
               end
            end else begin
               swing_in = '0;
            end
         end
         MODE_EFFECT: begin
            if (tick.anim_finished && tick.sound_finished) begin
               swing_in = '0;
               mode_in  = MODE_ON;
            end
         end
         MODE_OFF: begin
            if (tick.anim_finished && tick.sound_finished) begin
               idle_in = '0;
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            mode_in = MODE_SLEEP;
         end
      endcase

      result_in.font_index = font_in;
      result_in.mode_now   = mode_in;
   end

   always_comb begin
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SLEEP;
         idle_ff      <= '0;
         swing_ff     <= '0;
         font_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            mode_ff  <= mode_in;
            idle_ff  <= idle_in;
            swing_ff <= swing_in;
            font_ff  <= font_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.sound_start = result_ff.sound_start;
   assign rsp_bus.sound_kind  = result_ff.sound_kind;
   assign rsp_bus.anim_start  = result_ff.anim_start;
   assign rsp_bus.anim_kind   = result_ff.anim_kind;
   assign rsp_bus.anim_dark   = result_ff.anim_dark;
   assign rsp_bus.font_index  = result_ff.font_index;
   assign rsp_bus.mode_now    = result_ff.mode_now;
   assign rsp_bus.sleep_now   = result_ff.sleep_now;

endmodule
